/* rtl/core/bary_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bary_pkg
// Shared types and constants of the barycentric weight core.
// ----------------------------------------------------------------------------
package bary_pkg;

	localparam int WEIGHT_BITS = 32;
	// quotient bits kept by the divider: integer and fraction part plus one rounding bit
	localparam int QUOT_BITS   = 33;

	typedef struct packed {
		logic neg_b;
		logic neg_c;
		logic degen;
		logic ovf_b;
		logic ovf_c;
	} bary_flags_t;

endpackage

`default_nettype wire

/* rtl/core/bary_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bary_in_if
// Query item channel: point and three triangle corners.
// ----------------------------------------------------------------------------
interface bary_in_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] corner0_x;
	logic signed [COORD_BITS-1:0] corner0_y;
	logic signed [COORD_BITS-1:0] corner1_x;
	logic signed [COORD_BITS-1:0] corner1_y;
	logic signed [COORD_BITS-1:0] corner2_x;
	logic signed [COORD_BITS-1:0] corner2_y;

	modport source (
		output valid, point_x, point_y, corner0_x, corner0_y,
		       corner1_x, corner1_y, corner2_x, corner2_y,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, corner0_x, corner0_y,
		       corner1_x, corner1_y, corner2_x, corner2_y,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/core/bary_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bary_out_if
// Result item channel: three weights and status flags.
// ----------------------------------------------------------------------------
interface bary_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] weight_a;
	logic signed [31:0] weight_b;
	logic signed [31:0] weight_c;
	logic               coords_valid;
	logic               saturated;

	modport source (
		output valid, weight_a, weight_b, weight_c, coords_valid, saturated,
		input  ready
	);
	modport sink (
		input  valid, weight_a, weight_b, weight_c, coords_valid, saturated,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/core/barycentric_coordinates_2d_core.sv */
// Depth: 40 register stages between an accepted item and its result
//   (4 cross-product, overflow check, 33 divider, 2 output); the 33 stage
//   restoring divider pair sets the depth and each stage holds one item.
// Throughput: one item per cycle unless stalled; bubbles collapse under stall.
// Reset: arst_n clears all stage valid bits asynchronously; data registers
//   are not reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barycentric_coordinates_2d_core
// Barycentric weights of a point in a 2D triangle, signed fixed point.
// ----------------------------------------------------------------------------
module barycentric_coordinates_2d_core
	import bary_pkg::*;
#(
	parameter int COORD_BITS       = 16,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	bary_in_if.sink      req,
	bary_out_if.source   rsp
);
	localparam int AW = 2 * COORD_BITS + 2;

	logic                 x_v, x_rdy, d_v, d_rdy;
	logic [AW-1:0]        abs_b, abs_c, abs_d;
	bary_flags_t          x_flags, d_flags;
	logic [QUOT_BITS-1:0] quot_b, quot_c;

	bary_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.out_v   (x_v),
		.out_rdy (x_rdy),
		.abs_b   (abs_b),
		.abs_c   (abs_c),
		.abs_d   (abs_d),
		.flags   (x_flags)
	);

	bary_div #(
		.COORD_BITS       (COORD_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_v      (x_v),
		.in_rdy    (x_rdy),
		.abs_b     (abs_b),
		.abs_c     (abs_c),
		.abs_d     (abs_d),
		.in_flags  (x_flags),
		.out_v     (d_v),
		.out_rdy   (d_rdy),
		.quot_b    (quot_b),
		.quot_c    (quot_c),
		.out_flags (d_flags)
	);

	bary_out #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (d_v),
		.in_rdy   (d_rdy),
		.quot_b   (quot_b),
		.quot_c   (quot_c),
		.in_flags (d_flags),
		.rsp      (rsp)
	);

`ifndef ASSERT_OFF
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.coords_valid |->
			rsp.weight_a == '0 && rsp.weight_b == '0 && rsp.weight_c == '0 &&
			!rsp.saturated)
		else $error("degenerate item with nonzero fields");

	a_sum_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.coords_valid && !rsp.saturated |->
			WEIGHT_BITS'(rsp.weight_a + rsp.weight_b + rsp.weight_c) ==
			(WEIGHT_BITS'(1) << WEIGHT_FRAC_BITS))
		else $error("unsaturated weights do not sum to one");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.coords_valid && rsp.saturated |->
			rsp.weight_a == 32'sh7fffffff || rsp.weight_a == 32'sh80000000 ||
			rsp.weight_b == 32'sh7fffffff || rsp.weight_b == 32'sh80000000 ||
			rsp.weight_c == 32'sh7fffffff || rsp.weight_c == 32'sh80000000)
		else $error("saturated flag without a clipped weight");
`endif

endmodule

`default_nettype wire

/* rtl/core/bary_cross.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bary_cross
// Edge vectors, products and the three cross products, then magnitudes and
// signs. Four stages.
// ----------------------------------------------------------------------------
module bary_cross
	import bary_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	bary_in_if.sink             req,
	output logic                out_v,
	input  wire                 out_rdy,
	output logic [2*COORD_BITS+1:0] abs_b,
	output logic [2*COORD_BITS+1:0] abs_c,
	output logic [2*COORD_BITS+1:0] abs_d,
	output bary_flags_t         flags
);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;
	localparam int XW = 2 * COORD_BITS + 3;
	localparam int AW = 2 * COORD_BITS + 2;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	logic signed [DW-1:0] e0x_s1, e0y_s1, e1x_s1, e1y_s1, e2x_s1, e2y_s1;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [XW-1:0] den_s3, nb_s3, nc_s3;

	assign adv4      = !v_s4 || out_rdy;
	assign adv3      = !v_s3 || adv4;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign req.ready = adv1;
	assign out_v     = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			e0x_s1 <= DW'(req.corner1_x) - DW'(req.corner0_x);
			e0y_s1 <= DW'(req.corner1_y) - DW'(req.corner0_y);
			e1x_s1 <= DW'(req.corner2_x) - DW'(req.corner0_x);
			e1y_s1 <= DW'(req.corner2_y) - DW'(req.corner0_y);
			e2x_s1 <= DW'(req.point_x) - DW'(req.corner0_x);
			e2y_s1 <= DW'(req.point_y) - DW'(req.corner0_y);
		end
		if (adv2) begin
			p0_s2 <= PW'(e0x_s1) * PW'(e1y_s1);
			p1_s2 <= PW'(e0y_s1) * PW'(e1x_s1);
			p2_s2 <= PW'(e2x_s1) * PW'(e1y_s1);
			p3_s2 <= PW'(e2y_s1) * PW'(e1x_s1);
			p4_s2 <= PW'(e0x_s1) * PW'(e2y_s1);
			p5_s2 <= PW'(e0y_s1) * PW'(e2x_s1);
		end
		if (adv3) begin
			den_s3 <= XW'(p0_s2) - XW'(p1_s2);
			nb_s3  <= XW'(p2_s2) - XW'(p3_s2);
			nc_s3  <= XW'(p4_s2) - XW'(p5_s2);
		end
		if (adv4) begin
			abs_d       <= AW'(den_s3[XW-1] ? -den_s3 : den_s3);
			abs_b       <= AW'(nb_s3[XW-1] ? -nb_s3 : nb_s3);
			abs_c       <= AW'(nc_s3[XW-1] ? -nc_s3 : nc_s3);
			flags.neg_b <= nb_s3[XW-1] ^ den_s3[XW-1];
			flags.neg_c <= nc_s3[XW-1] ^ den_s3[XW-1];
			flags.degen <= (den_s3 == '0);
			flags.ovf_b <= 1'b0;
			flags.ovf_c <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/bary_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bary_div
// Two restoring dividers in lockstep, one quotient bit per stage, after an
// overflow pre-check stage.
// ----------------------------------------------------------------------------
module bary_div
	import bary_pkg::*;
#(
	parameter int COORD_BITS       = 16,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_v,
	output logic                    in_rdy,
	input  wire [2*COORD_BITS+1:0]  abs_b,
	input  wire [2*COORD_BITS+1:0]  abs_c,
	input  wire [2*COORD_BITS+1:0]  abs_d,
	input  bary_flags_t             in_flags,
	output logic                    out_v,
	input  wire                     out_rdy,
	output logic [QUOT_BITS-1:0]    quot_b,
	output logic [QUOT_BITS-1:0]    quot_c,
	output bary_flags_t             out_flags
);
	localparam int AW = 2 * COORD_BITS + 2;
	localparam int SH = 31 - WEIGHT_FRAC_BITS;
	localparam int TW = AW + SH + 2;
	localparam int NS = QUOT_BITS + 1;

	logic                 v_s   [NS];
	logic                 adv   [NS+1];
	logic [AW-1:0]        an_b_s [NS];
	logic [AW-1:0]        an_c_s [NS];
	logic [AW-1:0]        ad_s   [NS];
	logic [AW-1:0]        rem_b_s [NS];
	logic [AW-1:0]        rem_c_s [NS];
	logic [QUOT_BITS-1:0] q_b_s  [NS];
	logic [QUOT_BITS-1:0] q_c_s  [NS];
	bary_flags_t          fl_s   [NS];

	logic [TW-1:0] thr;
	bary_flags_t   fl_in;

	assign adv[NS] = out_rdy;
	assign in_rdy  = adv[0];
	assign out_v   = v_s[NS-1];
	assign quot_b  = q_b_s[NS-1];
	assign quot_c  = q_c_s[NS-1];
	assign out_flags = fl_s[NS-1];

	// quotient overflows when an >= ad * (2^SH + 1)
	assign thr = (TW'(abs_d) << SH) + TW'(abs_d);

	always_comb begin
		fl_in       = in_flags;
		fl_in.ovf_b = (TW'(abs_b) >= thr);
		fl_in.ovf_c = (TW'(abs_c) >= thr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv[0]) begin
			v_s[0] <= in_v;
		end
	end

	assign adv[0] = !v_s[0] || adv[1];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			an_b_s[0]    <= abs_b;
			an_c_s[0]    <= abs_c;
			ad_s[0]      <= abs_d;
			rem_b_s[0]   <= AW'(abs_b >> (SH + 1));
			rem_c_s[0]   <= AW'(abs_c >> (SH + 1));
			q_b_s[0]     <= '0;
			q_c_s[0]     <= '0;
			fl_s[0]      <= fl_in;
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_step
		localparam int P = SH - (k - 1);
		logic          bit_b, bit_c;
		logic [AW:0]   t_b, t_c;
		logic          ge_b, ge_c;

		if (P >= 0 && P < AW) begin : g_bit
			assign bit_b = an_b_s[k-1][P];
			assign bit_c = an_c_s[k-1][P];
		end else begin : g_zero
			assign bit_b = 1'b0;
			assign bit_c = 1'b0;
		end

		assign t_b  = {rem_b_s[k-1], bit_b};
		assign t_c  = {rem_c_s[k-1], bit_c};
		assign ge_b = (t_b >= {1'b0, ad_s[k-1]});
		assign ge_c = (t_c >= {1'b0, ad_s[k-1]});
		assign adv[k] = !v_s[k] || adv[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				an_b_s[k]  <= an_b_s[k-1];
				an_c_s[k]  <= an_c_s[k-1];
				ad_s[k]    <= ad_s[k-1];
				fl_s[k]    <= fl_s[k-1];
				rem_b_s[k] <= ge_b ? AW'(t_b - {1'b0, ad_s[k-1]}) : AW'(t_b);
				rem_c_s[k] <= ge_c ? AW'(t_c - {1'b0, ad_s[k-1]}) : AW'(t_c);
				q_b_s[k]   <= {q_b_s[k-1][QUOT_BITS-2:0], ge_b};
				q_c_s[k]   <= {q_c_s[k-1][QUOT_BITS-2:0], ge_c};
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/bary_out.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bary_out
// Rounding and saturation of the two quotients, then the corner 0 weight and
// the output register.
// ----------------------------------------------------------------------------
module bary_out
	import bary_pkg::*;
#(
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_v,
	output logic                 in_rdy,
	input  wire [QUOT_BITS-1:0]  quot_b,
	input  wire [QUOT_BITS-1:0]  quot_c,
	input  bary_flags_t          in_flags,
	bary_out_if.source           rsp
);
	localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
	localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
	localparam logic [QUOT_BITS-1:0] MAG_MIN = QUOT_BITS'(1) << (WEIGHT_BITS - 1);
	localparam logic signed [WEIGHT_BITS+1:0] ONE =
		(WEIGHT_BITS+2)'(1) << WEIGHT_FRAC_BITS;

	logic v_s1, v_s2;
	logic adv1, adv2;

	logic signed [WEIGHT_BITS-1:0] wb_s1, wc_s1;
	logic                          sat_s1, degen_s1;

	logic [QUOT_BITS-1:0]          mr_b, mr_c;
	logic signed [WEIGHT_BITS-1:0] wb, wc;
	logic                          sb, sc;
	logic signed [WEIGHT_BITS+1:0] wa_sum;
	logic                          sa;

	assign mr_b = QUOT_BITS'(({1'b0, quot_b} + 1'b1) >> 1);
	assign mr_c = QUOT_BITS'(({1'b0, quot_c} + 1'b1) >> 1);

	always_comb begin
		if (in_flags.ovf_b) begin
			sb = 1'b1;
			wb = in_flags.neg_b ? W_MIN : W_MAX;
		end else if (in_flags.neg_b) begin
			sb = (mr_b > MAG_MIN);
			wb = sb ? W_MIN : -WEIGHT_BITS'(mr_b);
		end else begin
			sb = (mr_b > QUOT_BITS'(W_MAX));
			wb = sb ? W_MAX : WEIGHT_BITS'(mr_b);
		end
		if (in_flags.ovf_c) begin
			sc = 1'b1;
			wc = in_flags.neg_c ? W_MIN : W_MAX;
		end else if (in_flags.neg_c) begin
			sc = (mr_c > MAG_MIN);
			wc = sc ? W_MIN : -WEIGHT_BITS'(mr_c);
		end else begin
			sc = (mr_c > QUOT_BITS'(W_MAX));
			wc = sc ? W_MAX : WEIGHT_BITS'(mr_c);
		end
	end

	assign wa_sum = ONE - (WEIGHT_BITS+2)'(wb_s1) - (WEIGHT_BITS+2)'(wc_s1);
	assign sa     = (wa_sum[WEIGHT_BITS+1:WEIGHT_BITS-1] != '0) &&
	                (wa_sum[WEIGHT_BITS+1:WEIGHT_BITS-1] != '1);

	assign adv2      = !v_s2 || rsp.ready;
	assign adv1      = !v_s1 || adv2;
	assign in_rdy    = adv1;
	assign rsp.valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_v;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			wb_s1    <= wb;
			wc_s1    <= wc;
			sat_s1   <= sb || sc;
			degen_s1 <= in_flags.degen;
		end
		if (adv2) begin
			if (degen_s1) begin
				rsp.weight_a     <= '0;
				rsp.weight_b     <= '0;
				rsp.weight_c     <= '0;
				rsp.coords_valid <= 1'b0;
				rsp.saturated    <= 1'b0;
			end else begin
				rsp.weight_a     <= sa ? (wa_sum[WEIGHT_BITS+1] ? W_MIN : W_MAX)
				                       : WEIGHT_BITS'(wa_sum);
				rsp.weight_b     <= wb_s1;
				rsp.weight_c     <= wc_s1;
				rsp.coords_valid <= 1'b1;
				rsp.saturated    <= sat_s1 || sa;
			end
		end
	end

endmodule

`default_nettype wire

/* tb/sv/bary_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bary_checker
// Watches the query and weight channels, computes the expected weights of
// every accepted query item and compares each result item field by field.
// ----------------------------------------------------------------------------
module bary_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        in_ready,
	input  wire [15:0] px, py, ax, ay, bx, by, cx, cy,
	input  wire        out_valid,
	input  wire        out_ready,
	input  wire [31:0] wa, wb, wc,
	input  wire        cv,
	input  wire        sat,
	output int         fail_count,
	output int         pending,
	output int         results_seen,
	output int         degen_seen,
	output int         sat_seen
);
	typedef struct packed {
		logic [31:0] wa;
		logic [31:0] wb;
		logic [31:0] wc;
		logic        cv;
		logic        sat;
	} weights_t;

	weights_t weights_q[$];

	localparam longint W_MAX = 64'sd2147483647;
	localparam longint W_MIN = -64'sd2147483648;

	function automatic longint divide_weight(longint num, longint den, inout bit clip);
		bit        neg;
		logic [63:0] an, ad, q, r, m;
		neg = (num < 0) != (den < 0);
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		q = an / ad;
		r = an % ad;
		if (q > 64'd32768) begin
			clip = 1;
			return neg ? W_MIN : W_MAX;
		end
		m = q;
		for (int i = 0; i < 17; i++) begin
			r = r << 1;
			m = m << 1;
			if (r >= ad) begin
				r = r - ad;
				m[0] = 1'b1;
			end
		end
		m = (m + 1) >> 1;
		if (neg) begin
			if (m > 64'd2147483648) begin
				clip = 1;
				return W_MIN;
			end
			return -longint'(m);
		end
		if (m > 64'd2147483647) begin
			clip = 1;
			return W_MAX;
		end
		return longint'(m);
	endfunction

	function automatic weights_t barycentric_weights(logic [15:0] qx, qy, x0, y0, x1, y1,
		x2, y2);
		longint e0x, e0y, e1x, e1y, e2x, e2y, den, nb, nc, a, b, c;
		bit clip;
		weights_t w;
		e0x = longint'($signed(x1)) - longint'($signed(x0));
		e0y = longint'($signed(y1)) - longint'($signed(y0));
		e1x = longint'($signed(x2)) - longint'($signed(x0));
		e1y = longint'($signed(y2)) - longint'($signed(y0));
		e2x = longint'($signed(qx)) - longint'($signed(x0));
		e2y = longint'($signed(qy)) - longint'($signed(y0));
		den = e0x * e1y - e0y * e1x;
		nb = e2x * e1y - e2y * e1x;
		nc = e0x * e2y - e0y * e2x;
		w = '0;
		if (den == 0) return w;
		clip = 0;
		b = divide_weight(nb, den, clip);
		c = divide_weight(nc, den, clip);
		a = 65536 - b - c;
		if (a > W_MAX) begin
			a = W_MAX;
			clip = 1;
		end else if (a < W_MIN) begin
			a = W_MIN;
			clip = 1;
		end
		w.wa = a[31:0];
		w.wb = b[31:0];
		w.wc = c[31:0];
		w.cv = 1'b1;
		w.sat = clip;
		return w;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch on result %0d: %s got %h expected %h", results_seen, field,
			got, want);
		fail_count++;
	endtask

	assign pending = weights_q.size();

	initial begin
		fail_count = 0;
		results_seen = 0;
		degen_seen = 0;
		sat_seen = 0;
	end

	always @(posedge clk) begin
		weights_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				weights_q.insert(weights_q.size(),
					barycentric_weights(px, py, ax, ay, bx, by, cx, cy));
			if (out_valid && out_ready) begin
				if (weights_q.size() == 0) begin
					$display("unexpected result item %0d", results_seen);
					fail_count++;
				end else begin
					want = weights_q.pop_front();
					if (wa !== want.wa) report_mismatch("weight_a", wa, want.wa);
					if (wb !== want.wb) report_mismatch("weight_b", wb, want.wb);
					if (wc !== want.wc) report_mismatch("weight_c", wc, want.wc);
					if (cv !== want.cv) report_mismatch("coords_valid", cv, want.cv);
					if (sat !== want.sat) report_mismatch("saturated", sat, want.sat);
					if (!want.cv) degen_seen++;
					if (want.sat) sat_seen++;
				end
				results_seen++;
			end
		end
	end
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the barycentric weight core: directed corner cases, then
// random triangles and points with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
	localparam int RANDOM_ITEMS = 450;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending, results_seen, degen_seen, sat_seen;
	int   idle_cycles = 0;
	bit   timed_out = 0;

	bary_in_if #(.COORD_BITS(16)) req ();
	bary_out_if rsp ();

	barycentric_coordinates_2d_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	bary_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req.valid),
		.in_ready     (req.ready),
		.px           (req.point_x),
		.py           (req.point_y),
		.ax           (req.corner0_x),
		.ay           (req.corner0_y),
		.bx           (req.corner1_x),
		.by           (req.corner1_y),
		.cx           (req.corner2_x),
		.cy           (req.corner2_y),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.wa           (rsp.weight_a),
		.wb           (rsp.weight_b),
		.wc           (rsp.weight_c),
		.cv           (rsp.coords_valid),
		.sat          (rsp.saturated),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.degen_seen   (degen_seen),
		.sat_seen     (sat_seen)
	);

	always #6 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.point_x = '0;
		req.point_y = '0;
		req.corner0_x = '0;
		req.corner0_y = '0;
		req.corner1_x = '0;
		req.corner1_y = '0;
		req.corner2_x = '0;
		req.corner2_y = '0;
		rsp.ready = 1'b0;
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", idle_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: random stall per item, with stall-free stretches
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	function automatic logic [15:0] rand_coord(int mode);
		case (mode)
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 64)) - 16'd32;
			3: return 16'($urandom_range(0, 2048)) - 16'd1024;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_query(logic [15:0] qx, qy, x0, y0, x1, y1, x2, y2);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.point_x <= qx;
		req.point_y <= qy;
		req.corner0_x <= x0;
		req.corner0_y <= y0;
		req.corner1_x <= x1;
		req.corner1_y <= y1;
		req.corner2_x <= x2;
		req.corner2_y <= y2;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	initial begin
		logic [15:0] v[8];
		int mode;
		int drain;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit triangle, centroid-ish point, corners themselves
		send_query(16'h0040, 16'h0040, 16'h0000, 16'h0000, 16'h0100, 16'h0000,
			16'h0000, 16'h0100);
		send_query(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000,
			16'h0000, 16'h0100);
		send_query(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000,
			16'h0000, 16'h0100);
		// clockwise winding, point outside
		send_query(16'hff00, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
			16'h0100, 16'h0000);
		// degenerate: all corners equal, collinear corners
		send_query(16'h1234, 16'h4321, 16'h0100, 16'h0100, 16'h0100, 16'h0100,
			16'h0100, 16'h0100);
		send_query(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100,
			16'h0200, 16'h0200);
		// tiny triangle with far point: saturation
		send_query(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
			16'h0000, 16'h0001);
		send_query(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
			16'h0000, 16'h0001);
		send_query(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7ffe, 16'h8000,
			16'h7fff, 16'h8001);
		// full-range triangle
		send_query(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
			16'h8000, 16'h7fff);
		send_query(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
			16'h8000, 16'h7fff);
		// rounding ties: thirds and halves
		send_query(16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0003, 16'h0000,
			16'h0000, 16'h0003);
		send_query(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0002, 16'h0000,
			16'h0000, 16'h0002);
		send_query(16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'hfffd, 16'h0000,
			16'h0000, 16'h0003);
		send_query(16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'hffff,
			16'h0000, 16'h0001);
		send_query(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'hffff, 16'h0000,
			16'h0000, 16'hffff);
		req.valid <= 1'b0;

		// let the pipeline drain completely before the random part
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			mode = $urandom_range(0, 9);
			for (int k = 0; k < 8; k++)
				v[k] = rand_coord((mode < 2) ? $urandom_range(0, 4) :
					(mode < 5) ? 3 : (mode < 7) ? 4 : 2);
			if (mode == 9) begin
				// degenerate: corner 2 on the line of corners 0 and 1
				v[6] = v[2] + 16'd2 * (v[4] - v[2]);
				v[7] = v[3] + 16'd2 * (v[5] - v[3]);
			end
			send_query(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
		end
		req.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		drain = 0;
		while (drain < 60) begin
			@(posedge clk);
			drain++;
		end

		$display("covered %0d results, %0d degenerate, %0d saturated", results_seen,
			degen_seen, sat_seen);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
